// File: hdl/vrle_pkg.sv
// Package for the voxel run-length encoder: field widths, register indexes,
// result and transfer structures shared by all files of the block.
// Depends on nothing.
package vrle_pkg;

    localparam int COLOR_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int VERSION_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_REPLACEMENT = 1'd1;

    // The only format version that collapses every nonzero solid code to one.
    localparam logic [VERSION_W-1:0] VERSION_COLLAPSE = 2'd1;
    localparam logic [VERSION_W-1:0] VERSION_RESET    = 2'd1;

    localparam logic [COLOR_W-1:0] CODE_EMPTY = 8'd0;
    localparam logic [COLOR_W-1:0] CODE_SOLID = 8'd1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [VERSION_W-1:0] format_version;
        logic [COLOR_W-1:0]   empty_replacement;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] run_value;
        logic [COUNT_W-1:0] run_length;
        logic               final_run;
    } result_t;

    // Up to two results produced by one voxel, in emission order.
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

endpackage

// File: hdl/vrle_voxel_if.sv
// Voxel input channel: valid/ready handshake with one voxel as payload.
// Depends on vrle_pkg.
interface vrle_voxel_if;
    import vrle_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_empty;
    logic [COLOR_W-1:0] color_index;
    logic               last_voxel;

    modport source (output valid, output is_empty, output color_index, output last_voxel,
                    input ready);
    modport sink (input valid, input is_empty, input color_index, input last_voxel,
                  output ready);
endinterface

// File: hdl/vrle_run_if.sv
// Run output channel: valid/ready handshake with one (value, length) run.
// Depends on vrle_pkg.
interface vrle_run_if;
    import vrle_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] run_value;
    logic [COUNT_W-1:0] run_length;
    logic               final_run;

    modport source (output valid, output run_value, output run_length, output final_run,
                    input ready);
    modport sink (input valid, input run_value, input run_length, input final_run,
                  output ready);
endinterface

// File: hdl/vrle_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on vrle_pkg.
interface vrle_cfg_if;
    import vrle_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/vrle_voxel_coder.sv
// Maps one voxel to its one-byte run code under the current configuration.
// Depends on vrle_pkg.
module vrle_voxel_coder (
    input  vrle_pkg::cfg_t              cfg,
    input  logic                        is_empty,
    input  logic [vrle_pkg::COLOR_W-1:0] color_index,
    output logic [vrle_pkg::COLOR_W-1:0] code
);
    import vrle_pkg::*;

    logic [COLOR_W-1:0] solid_code;

    always_comb
    begin
        // A solid voxel of colour zero borrows the replacement colour.
        solid_code = (color_index == CODE_EMPTY) ? cfg.empty_replacement : color_index;
        if (is_empty)
        begin
            code = CODE_EMPTY;
        end
        else if (cfg.format_version == VERSION_COLLAPSE && solid_code != CODE_EMPTY)
        begin
            code = CODE_SOLID;
        end
        else
        begin
            code = solid_code;
        end
    end
endmodule

// File: hdl/vrle_run_tracker.sv
// Holds the open run and decides, per accepted voxel, which runs close.
// Depends on vrle_pkg.
module vrle_run_tracker #(
    parameter int MAX_RUN = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [vrle_pkg::COLOR_W-1:0] code,
    input  logic                         last_voxel,
    output vrle_pkg::push_t              push
);
    import vrle_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_RUN);

    logic [COLOR_W-1:0] open_value_reg;
    logic [COLOR_W-1:0] open_value_next;
    logic [COUNT_W-1:0] open_count_reg;
    logic [COUNT_W-1:0] open_count_next;
    logic               close_run;
    logic               emit_closed;
    logic [COUNT_W-1:0] new_count;
    result_t            closed_run;
    result_t            flushed_run;

    always_comb
    begin
        close_run   = (code != open_value_reg) || (open_count_reg >= MAX_COUNT);
        emit_closed = close_run && (open_count_reg != '0);
        new_count   = (close_run ? '0 : open_count_reg) + COUNT_W'(1);

        closed_run.run_value   = open_value_reg;
        closed_run.run_length  = open_count_reg;
        closed_run.final_run   = 1'b0;
        flushed_run.run_value  = code;
        flushed_run.run_length = new_count;
        flushed_run.final_run  = 1'b1;

        // The closed run always goes out ahead of the flushed final run.
        push.first_valid  = accept && (emit_closed || last_voxel);
        push.second_valid = accept && emit_closed && last_voxel;
        push.first        = emit_closed ? closed_run : flushed_run;
        push.second       = flushed_run;

        open_value_next = open_value_reg;
        open_count_next = open_count_reg;
        if (accept)
        begin
            if (last_voxel)
            begin
                open_value_next = CODE_EMPTY;
                open_count_next = '0;
            end
            else
            begin
                open_value_next = code;
                open_count_next = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_value_reg <= CODE_EMPTY;
            open_count_reg <= '0;
        end
        else
        begin
            open_value_reg <= open_value_next;
            open_count_reg <= open_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_voxel) |=> (open_count_reg == '0 && open_value_reg == CODE_EMPTY))
        else $error("open run not cleared after the last voxel");

    assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= MAX_COUNT)
        else $error("open run longer than the maximum run");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |->
            (push.first_valid && !push.first.final_run && push.second.final_run))
        else $error("double result out of order");
endmodule

// File: hdl/vrle_result_fifo.sv
// Result queue: takes up to two runs per cycle, hands one run per cycle onwards while popped.
// Depends on vrle_pkg.
module vrle_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  vrle_pkg::push_t   push,
    input  logic              pop,
    output logic              out_valid,
    output vrle_pkg::result_t out_data,
    output logic              has_room
);
    import vrle_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic [FIFO_CNT_W-1:0]  count_next;
    logic [FIFO_CNT_W-1:0]  push_count;
    logic [FIFO_PTR_W-1:0]  wr_ptr_plus1;

    always_comb
    begin
        push_count   = FIFO_CNT_W'(push.first_valid) + FIFO_CNT_W'(push.second_valid);
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + push_count[FIFO_PTR_W-1:0];
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next   = count_reg + push_count - FIFO_CNT_W'(pop);
        out_valid    = (count_reg != '0);
        out_data     = mem[rd_ptr_reg];
        // Room for a voxel that may produce two results.
        has_room     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.first_valid |-> (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for two");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> out_valid)
        else $error("result taken from an empty queue");
endmodule

// File: hdl/voxel_run_length_encoder.sv
// Voxel run-length encoder: one voxel per cycle in, (value, length) runs out.
// Each run is written into a four-entry result queue that feeds run_out in order.
// Throughput: one voxel per cycle while voxel_in.ready is high; a voxel that both closes
// a run and flushes gives two runs, drained one per cycle while run_out.ready is high.
// voxel_in.ready is high while the queue holds at most two runs; cfg.ready is always high.
// Reset: no open run, queue empty, format_version 1, empty_replacement 0.
module voxel_run_length_encoder #(
    parameter int MAX_RUN = 255
) (
    input  logic      clk,
    input  logic      rst_n,
    vrle_voxel_if.sink voxel_in,
    vrle_run_if.source run_out,
    vrle_cfg_if.sink   cfg
);
    import vrle_pkg::*;

    // Configuration registers. Writes must arrive only while the block is idle; the block
    // itself does not enforce this, and the coder reads them directly without any shadowing.
    logic [VERSION_W-1:0] format_version_reg;
    logic [COLOR_W-1:0]   empty_replacement_reg;
    cfg_t                 cfg_word;

    logic               voxel_accept;
    logic [COLOR_W-1:0] code;
    push_t              push;
    result_t            head;
    logic               queue_valid;
    logic               queue_room;
    logic               run_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_version_reg    <= VERSION_RESET;
            empty_replacement_reg <= CODE_EMPTY;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FORMAT_VERSION:
                begin
                    format_version_reg <= cfg.data[VERSION_W-1:0];
                end
                REG_EMPTY_REPLACEMENT:
                begin
                    empty_replacement_reg <= cfg.data[COLOR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_word.format_version    = format_version_reg;
        cfg_word.empty_replacement = empty_replacement_reg;
    end

    // A voxel is taken whenever the queue can absorb the worst case of two runs.
    // Ready depends only on the queue fill, never on run_out.ready, so there is
    // no combinational path from the output side back to the input side.
    assign voxel_in.ready = queue_room;
    assign voxel_accept   = voxel_in.valid && queue_room;

    vrle_voxel_coder u_coder (
        .cfg         (cfg_word),
        .is_empty    (voxel_in.is_empty),
        .color_index (voxel_in.color_index),
        .code        (code)
    );

    // The open run lives here: its value and count are compared with each new code,
    // and closed or flushed runs are pushed into the queue in order.
    vrle_run_tracker #(
        .MAX_RUN (MAX_RUN)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (voxel_accept),
        .code       (code),
        .last_voxel (voxel_in.last_voxel),
        .push       (push)
    );

    // The queue is the register stage between the tracker and the output channel,
    // so voxels keep flowing while a finished run waits to be transferred.
    vrle_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (run_pop),
        .out_valid (queue_valid),
        .out_data  (head),
        .has_room  (queue_room)
    );

    assign run_pop            = queue_valid && run_out.ready;
    assign run_out.valid      = queue_valid;
    assign run_out.run_value  = head.run_value;
    assign run_out.run_length = head.run_length;
    assign run_out.final_run  = head.final_run;
endmodule
